@@ hw/rtl/mexp_pkg.sv @@
// shared constants for the modular exponentiation block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mexp_pkg;

	// field widths
	localparam int BASE_W      = 63;
	localparam int EXP_FIELD_W = 32;
	localparam int RES_W       = 30;

	// default exponent bits in use
	localparam int DEF_EXP_WIDTH = 32;

	// the prime modulus, plain and doubled at the width of the product lane
	localparam int              LANE_W    = RES_W + 2;
	localparam logic [RES_W-1:0]  MOD_P   = 30'd1000000007;
	localparam logic [LANE_W-1:0] MOD_P1X = 32'd1000000007;
	localparam logic [LANE_W-1:0] MOD_P2X = 32'd2000000014;

endpackage : mexp_pkg

`default_nettype wire

@@ hw/rtl/modular_exponentiation.sv @@
// an item runs one base reduction pass, then one multiplier pass per exponent bit up to the highest set one;
//   a zero exponent or zero reduced base skips the multiplier passes
// one item at a time: a new beat is taken only after the last result has moved to the output register;
//   the one bit-serial multiplier pair works per exponent bit
// reset: arst_n clears the sequencer and output valid; data registers keep no reset value
`timescale 1ns / 1ps
`default_nettype none

module modular_exponentiation
	import mexp_pkg::*;
#(
	parameter int EXP_WIDTH = DEF_EXP_WIDTH
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [BASE_W-1:0]      base,
	input  wire logic [EXP_FIELD_W-1:0] exponent,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [RES_W-1:0]            residue
);

	// exponent bits in play: above the field width they are zero anyway
	localparam int EXP_USE = (EXP_WIDTH < 1) ? 1 :
		((EXP_WIDTH < EXP_FIELD_W) ? EXP_WIDTH : EXP_FIELD_W);

	// sequencer states
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RED  = 2'd1;
	localparam logic [1:0] S_MUL  = 2'd2;
	localparam logic [1:0] S_OUT  = 2'd3;

	logic [1:0]         state_q;
	logic [EXP_USE-1:0] e_q;
	logic [RES_W-1:0]   acc_q;
	logic [RES_W-1:0]   b_q;
	logic               out_valid_q;
	logic [RES_W-1:0]   residue_q;

	logic               accept;
	logic               slot_free;
	logic               red_done;
	logic [RES_W-1:0]   red_rem;
	logic               mul_start;
	logic               mul_done;
	logic [RES_W-1:0]   prod_acc;
	logic [RES_W-1:0]   prod_sq;
	logic [RES_W-1:0]   acc_nxt;
	logic [RES_W-1:0]   b_nxt;
	logic [EXP_USE-1:0] e_nxt;

	// base mod prime, one base bit per cycle
	mexp_reduce u_reduce (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.base   (base),
		.done   (red_done),
		.rem    (red_rem)
	);

	// square and conditional multiply of one exponent bit, in parallel lanes
	mexp_mulmod u_mulmod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mul_start),
		.op_acc   (acc_nxt),
		.op_b     (b_nxt),
		.done     (mul_done),
		.prod_acc (prod_acc),
		.prod_sq  (prod_sq)
	);

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	// output register can take a new beat when empty or being drained
	assign slot_free = !out_valid_q || out_ready;

	// next accumulator, squared base and exponent; also the operands of the next multiply
	always_comb begin
		acc_nxt   = acc_q;
		b_nxt     = b_q;
		e_nxt     = e_q;
		mul_start = 1'b0;
		case (state_q)
			S_RED: begin
				acc_nxt   = RES_W'(1);
				b_nxt     = red_rem;
				// zero base or zero exponent skips the multiplier altogether
				mul_start = red_done && (red_rem != '0) && (e_q != '0);
			end
			S_MUL: begin
				acc_nxt   = e_q[0] ? prod_acc : acc_q;
				b_nxt     = prod_sq;
				e_nxt     = e_q >> 1;
				// stop as soon as no set exponent bit is left
				mul_start = mul_done && (e_nxt != '0);
			end
			default: begin
				acc_nxt = acc_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept)
						state_q <= S_RED;
				end
				S_RED: begin
					if (red_done) begin
						if (red_rem == '0 || e_q == '0)
							state_q <= S_OUT;
						else
							state_q <= S_MUL;
					end
				end
				S_MUL: begin
					if (mul_done && e_nxt == '0)
						state_q <= S_OUT;
				end
				S_OUT: begin
					if (slot_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase

			if (state_q == S_OUT && slot_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// data path registers
	always_ff @(posedge clk) begin
		if (accept)
			e_q <= exponent[EXP_USE-1:0];
		if (state_q == S_RED && red_done) begin
			b_q <= red_rem;
			// zero base gives zero even for exponent zero
			acc_q <= (red_rem == '0) ? '0 : RES_W'(1);
		end
		if (state_q == S_MUL && mul_done) begin
			acc_q <= acc_nxt;
			b_q   <= b_nxt;
			e_q   <= e_nxt;
		end
		if (state_q == S_OUT && slot_free)
			residue_q <= acc_q;
	end

	assign out_valid = out_valid_q;
	assign residue   = residue_q;

endmodule : modular_exponentiation

`default_nettype wire

@@ hw/rtl/mexp_reduce.sv @@
// bit-serial reduction of the 63-bit base modulo the prime
// depends on mexp_pkg
`timescale 1ns / 1ps
`default_nettype none

module mexp_reduce
	import mexp_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [BASE_W-1:0] base,
	output logic                   done,
	output logic [RES_W-1:0]       rem
);

	localparam int CNT_W = $clog2(BASE_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BASE_W - 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [BASE_W-1:0] sh_q;
	logic [RES_W-1:0]  rem_q;

	logic [RES_W:0]    twice;
	logic [RES_W:0]    trial;
	logic [RES_W-1:0]  rem_nxt;

	// shift in one base bit msb first, keep remainder below the prime
	assign twice   = {rem_q, sh_q[BASE_W-1]};
	assign trial   = twice - {1'b0, MOD_P};
	assign rem_nxt = (twice >= {1'b0, MOD_P}) ? trial[RES_W-1:0] : twice[RES_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= base;
			rem_q <= '0;
		end else if (busy_q) begin
			sh_q  <= {sh_q[BASE_W-2:0], 1'b0};
			rem_q <= rem_nxt;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule : mexp_reduce

`default_nettype wire

@@ hw/rtl/mexp_mulmod.sv @@
// bit-serial dual modular multiplier: acc*b and b*b share the serial operand b
// depends on mexp_pkg
`timescale 1ns / 1ps
`default_nettype none

module mexp_mulmod
	import mexp_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [RES_W-1:0] op_acc,
	input  wire logic [RES_W-1:0] op_b,
	output logic                  done,
	output logic [RES_W-1:0]      prod_acc,
	output logic [RES_W-1:0]      prod_sq
);

	localparam int CNT_W = $clog2(RES_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(RES_W - 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [RES_W-1:0] ser_q;
	logic [RES_W-1:0] acc_q;
	logic [RES_W-1:0] bpar_q;
	logic [RES_W-1:0] ra_q;
	logic [RES_W-1:0] rs_q;
	logic [RES_W-1:0] ra_nxt;
	logic [RES_W-1:0] rs_nxt;

	// one horner step: 2r + bit*a, then fold back below the prime
	function automatic logic [RES_W-1:0] step(input logic [RES_W-1:0] r,
		input logic [RES_W-1:0] a, input logic bit_in);
		logic [LANE_W-1:0] t;
		logic [LANE_W-1:0] f;
		t = {1'b0, r, 1'b0} + (bit_in ? {2'b00, a} : '0);
		if (t >= MOD_P2X)
			f = t - MOD_P2X;
		else if (t >= MOD_P1X)
			f = t - MOD_P1X;
		else
			f = t;
		return f[RES_W-1:0];
	endfunction

	assign ra_nxt = step(ra_q, acc_q,  ser_q[RES_W-1]);
	assign rs_nxt = step(rs_q, bpar_q, ser_q[RES_W-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ser_q  <= op_b;
			acc_q  <= op_acc;
			bpar_q <= op_b;
			ra_q   <= '0;
			rs_q   <= '0;
		end else if (busy_q) begin
			ser_q <= {ser_q[RES_W-2:0], 1'b0};
			ra_q  <= ra_nxt;
			rs_q  <= rs_nxt;
		end
	end

	assign done     = done_q;
	assign prod_acc = ra_q;
	assign prod_sq  = rs_q;

endmodule : mexp_mulmod

`default_nettype wire

@@ hw/rtl/mexp_checker.sv @@
// port-level checks for modular_exponentiation, attached by bind
// depends on mexp_pkg and the top level's ports
`timescale 1ns / 1ps
`default_nettype none

module mexp_checker
	import mexp_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   in_valid,
	input wire logic                   in_ready,
	input wire logic [BASE_W-1:0]      base,
	input wire logic [EXP_FIELD_W-1:0] exponent,
	input wire logic                   out_valid,
	input wire logic                   out_ready,
	input wire logic [RES_W-1:0]       residue
);

	// a result beat is always a proper residue
	a_res_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (residue < MOD_P))
		else $error("residue not below the prime");

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(residue)))
		else $error("stalled result beat changed");

	// one item at a time: no second input beat right after one is taken
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken while an item is in flight");

	// a result takes more than the reduction pass, never appears right after an input beat
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !$rose(out_valid))
		else $error("result beat too early");

	// the base and exponent operands are only watched while an input beat waits
	a_in_known: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_ready) |=> (in_valid && $stable(base) && $stable(exponent)))
		else $error("waiting input beat changed");

endmodule : mexp_checker

bind modular_exponentiation mexp_checker u_mexp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.base      (base),
	.exponent  (exponent),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.residue   (residue)
);

`default_nettype wire

@@ bench/modular_exponentiation_test.sv @@
// self-checking testbench for modular_exponentiation: random and directed base/exponent beats
// depends on mexp_pkg and modular_exponentiation from the rtl folder
`timescale 1ns / 1ps

module modular_exponentiation_test;
	import mexp_pkg::*;

	// run shape
	localparam int unsigned JOB_COUNT  = 1950;
	localparam int unsigned CALM_LO    = 900;   // beats in this window see no random idling
	localparam int unsigned CALM_HI    = 1100;
	localparam int unsigned DRAIN_WAIT = 1100;  // worst latency of one item, rounded up
	// worst item: its work, the longest sender gap and the longest receiver stall, with margin
	localparam longint unsigned CYCLE_LIMIT = 64'(JOB_COUNT + 50) * 1200 * 4;
	localparam bit [63:0] PRIME = 64'(MOD_P);

	typedef struct {
		bit [BASE_W-1:0]      base;
		bit [EXP_FIELD_W-1:0] exponent;
		int unsigned          gap;    // idle cycles before this beat is offered
		bit                   drain;  // hold until all residues are back
	} exp_job_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic [BASE_W-1:0]      base = '0;
	logic [EXP_FIELD_W-1:0] exponent = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic [RES_W-1:0]       residue;

	exp_job_t         pending[$];      // jobs not yet offered to the block
	bit [RES_W-1:0]   residue_due[$];  // predicted residues, oldest first
	int unsigned      job_index = 0;
	int unsigned      offered = 0;     // beats raised on the input side
	int unsigned      in_beats = 0;    // beats accepted on the input side
	int unsigned      out_beats = 0;   // beats accepted on the output side
	int unsigned      failures = 0;
	longint unsigned  cycles = 0;

	modular_exponentiation i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.base      (base),
		.exponent  (exponent),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.residue   (residue)
	);

	always #4 clk = ~clk;

	// right-to-left square and multiply modulo the prime
	// a base that reduces to zero gives zero even for a zero exponent
	function automatic bit [RES_W-1:0] power_residue(bit [BASE_W-1:0] b,
			bit [EXP_FIELD_W-1:0] e);
		bit [63:0] sq;
		bit [63:0] acc;
		sq = {1'b0, b} % PRIME;
		if (sq == 0)
			return '0;
		acc = 1;
		for (int i = 0; i < EXP_FIELD_W; i++) begin
			if (e[i])
				acc = (acc * sq) % PRIME;
			sq = (sq * sq) % PRIME;
		end
		return acc[RES_W-1:0];
	endfunction

	function automatic void add_job(bit [BASE_W-1:0] b, bit [EXP_FIELD_W-1:0] e, bit drain);
		exp_job_t job;
		job.base     = b;
		job.exponent = e;
		job.drain    = drain;
		// a stretch of back-to-back beats in the calm window
		job.gap      = (job_index >= CALM_LO && job_index < CALM_HI) ? 0 : $urandom_range(0, 9);
		pending = {pending, job};
		job_index++;
	endfunction

	function automatic bit [BASE_W-1:0] random_base();
		bit [63:0] r;
		bit [63:0] k;
		k = 64'($urandom_range(1, 32'hFFFF_FFFF));
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: r = {$urandom, $urandom};
			5:             r = 64'($urandom_range(0, 1000));
			6:             r = PRIME * k;                              // reduces to zero
			7:             r = PRIME * k + 64'($urandom_range(0, 4)) - 64'd1;
			8:             r = ~({$urandom, $urandom} & {$urandom, $urandom});
			default:       r = 64'($urandom_range(0, 1000000006));
		endcase
		return r[BASE_W-1:0];
	endfunction

	function automatic bit [EXP_FIELD_W-1:0] random_exponent();
		bit [EXP_FIELD_W-1:0] r;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: r = $urandom;
			6:                r = $urandom_range(0, 40);
			7:                r = 32'd1 << $urandom_range(0, 31);
			8:                r = $urandom_range(0, 1) ? '1 : '0;
			default:          r = $urandom >> $urandom_range(0, 31);
		endcase
		return r;
	endfunction

	// fill the job list, release reset, then wait for everything to come back
	initial begin
		bit [63:0] max_base;
		max_base = 64'h7FFF_FFFF_FFFF_FFFF;

		// directed: zero base, multiples of the prime, zero exponent, field extremes
		add_job('0, '0, 1'b0);                                  // zero to the zero gives zero
		add_job('0, '1, 1'b0);
		add_job(BASE_W'(PRIME), '0, 1'b0);                      // prime reduces to zero
		add_job(BASE_W'(PRIME * 64'd3), 32'd5, 1'b0);
		add_job(BASE_W'(PRIME * 64'd9_000_000_000), '0, 1'b0);  // a large prime multiple
		add_job(BASE_W'(1), '0, 1'b0);                          // nonzero base, zero exponent
		add_job(BASE_W'(1), '1, 1'b0);
		add_job(BASE_W'(1), 32'd1, 1'b0);
		add_job(max_base[BASE_W-1:0], '1, 1'b0);
		add_job(max_base[BASE_W-1:0], '0, 1'b0);
		add_job(max_base[BASE_W-1:0] - 1'b1, 32'd1, 1'b0);
		add_job(BASE_W'(PRIME - 64'd1), 32'd2, 1'b0);           // minus one squared
		add_job(BASE_W'(PRIME - 64'd1), 32'd1, 1'b0);
		add_job(BASE_W'(PRIME + 64'd1), '1, 1'b0);
		add_job(BASE_W'(2), 32'd1, 1'b0);
		add_job(BASE_W'(2), 32'd31, 1'b0);
		add_job(BASE_W'(2), 32'd32, 1'b0);
		add_job(BASE_W'(2), 32'h8000_0000, 1'b0);               // only the top exponent bit
		add_job(BASE_W'(123456789), '1, 1'b0);
		add_job(BASE_W'(987654321), 32'h5555_5555, 1'b0);
		add_job(BASE_W'(987654321), 32'hAAAA_AAAA, 1'b0);
		add_job(BASE_W'(PRIME - 64'd2), 32'h0001_0000, 1'b0);
		add_job(BASE_W'(3), 32'hFFFF_FFFE, 1'b1);               // sender drains first

		// random part, with a second drain in the middle
		while (job_index < JOB_COUNT)
			add_job(random_base(), random_exponent(), job_index == JOB_COUNT / 2);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending.size() != 0 || in_beats != offered)
			@(posedge clk);
		while (residue_due.size() != 0)
			@(posedge clk);
		// catch any stray beat the block might still send
		repeat (DRAIN_WAIT) @(posedge clk);

		if (failures == 0 && residue_due.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// sender: idles for the job's gap, waits out a drain, holds the beat until taken
	always @(negedge clk) begin
		static int unsigned gap_left = 0;
		static bit          gap_armed = 1'b0;
		exp_job_t           job;
		bit                 busy;
		if (arst_n) begin
			busy = in_valid && (in_beats != offered);
			if (!busy) begin
				if (pending.size() == 0) begin
					in_valid <= 1'b0;
				end else begin
					if (!gap_armed) begin
						gap_left  = pending[0].gap;
						gap_armed = 1'b1;
					end
					if (gap_left > 0) begin
						gap_left--;
						in_valid <= 1'b0;
					end else if (pending[0].drain && residue_due.size() != 0) begin
						in_valid <= 1'b0;
					end else begin
						job = pending.pop_front();
						base      <= job.base;
						exponent  <= job.exponent;
						in_valid  <= 1'b1;
						offered++;
						gap_armed = 1'b0;
					end
				end
			end
		end
	end

	// receiver: after each beat, stalls for a random count before taking the next, none in the calm window
	always @(negedge clk) begin
		static int unsigned stall_left = 0;
		static int unsigned seen = 0;
		if (arst_n) begin
			if (seen != out_beats) begin
				seen = out_beats;
				stall_left = (out_beats >= CALM_LO && out_beats < CALM_HI) ? 0 :
					$urandom_range(0, 9);
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// monitor: predict on each input beat, compare each output beat
	always @(posedge clk) begin
		bit [RES_W-1:0] want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				residue_due = {residue_due, power_residue(base, exponent)};
				in_beats++;
			end
			if (out_valid && out_ready) begin
				out_beats++;
				if (residue_due.size() == 0) begin
					$error("residue beat with nothing expected: actual %0d", residue);
					failures++;
				end else begin
					want = residue_due.pop_front();
					if (residue !== want) begin
						$error("residue mismatch: expected %0d, actual %0d", want, residue);
						failures++;
					end
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

endmodule

@@ modular_exponentiation.f @@
hw/rtl/mexp_pkg.sv
hw/rtl/mexp_reduce.sv
hw/rtl/mexp_mulmod.sv
hw/rtl/modular_exponentiation.sv
hw/rtl/mexp_checker.sv
bench/modular_exponentiation_test.sv
